FILE: hdl/rotated_rect_sat_overlap_assert.svh
// Assertion macros shared by the overlap test RTL.
// Included by the modules that check their own pipeline behavior.
`ifndef ROTATED_RECT_SAT_OVERLAP_ASSERT_SVH
`define ROTATED_RECT_SAT_OVERLAP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RRS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rrs_pkg.sv
// Shared types, widths and helpers for the rotated rectangle overlap test.
// Used by rrs_cfg, rrs_cell and the top level; no dependencies.
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int COORD_BITS = 16;
  localparam int NORM_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = NORM_BITS + COORD_BITS;
  localparam int PROJ_BITS  = PROD_BITS + 1;
  localparam int CORNERS    = 4;
  localparam int AXES       = 2 * CORNERS;
  localparam int TDATA_BITS = 2 * CORNERS * COORD_BITS;
  localparam int ODATA_BITS = 8;
  localparam int IDX_BITS   = 4;

  // Register indexes of the reference corners
  localparam logic [IDX_BITS-1:0] REG_REF_X0 = 4'd0;
  localparam logic [IDX_BITS-1:0] REG_REF_Y0 = 4'd1;
  localparam logic [IDX_BITS-1:0] REG_REF_X1 = 4'd2;
  localparam logic [IDX_BITS-1:0] REG_REF_Y1 = 4'd3;
  localparam logic [IDX_BITS-1:0] REG_REF_X2 = 4'd4;
  localparam logic [IDX_BITS-1:0] REG_REF_Y2 = 4'd5;
  localparam logic [IDX_BITS-1:0] REG_REF_X3 = 4'd6;
  localparam logic [IDX_BITS-1:0] REG_REF_Y3 = 4'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NORM_BITS-1:0]  norm_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [PROJ_BITS-1:0]  proj_t;

  typedef struct packed {
    coord_t [CORNERS-1:0] x;
    coord_t [CORNERS-1:0] y;
  } quad_t;

  typedef struct packed {
    quad_t cand;
    logic  overlap;
  } item_t;

  function automatic proj_t proj_min(proj_t a, proj_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic proj_t proj_max(proj_t a, proj_t b);
    return (a < b) ? b : a;
  endfunction

endpackage

FILE: hdl/rrs_cfg.sv
// Reference rectangle register file, written through the config channel.
// Depends on rrs_pkg.
`timescale 1ns / 1ps

module rrs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrs_pkg::IDX_BITS-1:0]  cfg_index,
  input  rrs_pkg::coord_t               cfg_data,
  output rrs_pkg::quad_t                ref_quad
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_quad <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrs_pkg::REG_REF_X0: ref_quad.x[0] <= cfg_data;
        rrs_pkg::REG_REF_Y0: ref_quad.y[0] <= cfg_data;
        rrs_pkg::REG_REF_X1: ref_quad.x[1] <= cfg_data;
        rrs_pkg::REG_REF_Y1: ref_quad.y[1] <= cfg_data;
        rrs_pkg::REG_REF_X2: ref_quad.x[2] <= cfg_data;
        rrs_pkg::REG_REF_Y2: ref_quad.y[2] <= cfg_data;
        rrs_pkg::REG_REF_X3: ref_quad.x[3] <= cfg_data;
        rrs_pkg::REG_REF_Y3: ref_quad.y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/rrs_cell.sv
// One axis cell of the separating axis chain: normal, products, sums, extremes, check.
// Depends on rrs_pkg and rotated_rect_sat_overlap_assert.svh.
`timescale 1ns / 1ps
`include "rotated_rect_sat_overlap_assert.svh"

module rrs_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic [2:0]      axis,      // edge 0..3 of reference, 4..7 of candidate
  input  rrs_pkg::quad_t  ref_quad,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrs_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output rrs_pkg::item_t  out_item
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  rrs_pkg::item_t it1, it2, it3, it4, it5;

  rrs_pkg::norm_t nx1, ny1, nx_next, ny_next;
  rrs_pkg::prod_t pax2 [rrs_pkg::CORNERS];
  rrs_pkg::prod_t pay2 [rrs_pkg::CORNERS];
  rrs_pkg::prod_t pbx2 [rrs_pkg::CORNERS];
  rrs_pkg::prod_t pby2 [rrs_pkg::CORNERS];
  rrs_pkg::proj_t da3 [rrs_pkg::CORNERS];
  rrs_pkg::proj_t db3 [rrs_pkg::CORNERS];
  rrs_pkg::proj_t mna4, mxa4, mnb4, mxb4;
  rrs_pkg::quad_t src;
  logic [1:0]     ek, ej;
  logic           sep;

  // Each stage moves when it is empty or the next one moves
  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v5;
  assign out_item  = it5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Edge normal n = (y[j]-y[k], x[k]-x[j]) with j = k+1 mod 4
  always_comb begin
    src     = axis[2] ? in_item.cand : ref_quad;
    ek      = axis[1:0];
    ej      = ek + 2'd1;
    nx_next = rrs_pkg::norm_t'(src.y[ej]) - rrs_pkg::norm_t'(src.y[ek]);
    ny_next = rrs_pkg::norm_t'(src.x[ek]) - rrs_pkg::norm_t'(src.x[ej]);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1 <= in_item;
      nx1 <= nx_next;
      ny1 <= ny_next;
    end
  end

  // Project every corner of both shapes onto the normal
  always_ff @(posedge clk) begin
    if (en2) begin
      it2 <= it1;
      for (int k = 0; k < rrs_pkg::CORNERS; k++) begin
        pax2[k] <= rrs_pkg::prod_t'(nx1) * rrs_pkg::prod_t'(ref_quad.x[k]);
        pay2[k] <= rrs_pkg::prod_t'(ny1) * rrs_pkg::prod_t'(ref_quad.y[k]);
        pbx2[k] <= rrs_pkg::prod_t'(nx1) * rrs_pkg::prod_t'(it1.cand.x[k]);
        pby2[k] <= rrs_pkg::prod_t'(ny1) * rrs_pkg::prod_t'(it1.cand.y[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      it3 <= it2;
      for (int k = 0; k < rrs_pkg::CORNERS; k++) begin
        da3[k] <= rrs_pkg::proj_t'(pax2[k]) + rrs_pkg::proj_t'(pay2[k]);
        db3[k] <= rrs_pkg::proj_t'(pbx2[k]) + rrs_pkg::proj_t'(pby2[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      it4  <= it3;
      mna4 <= rrs_pkg::proj_min(rrs_pkg::proj_min(da3[0], da3[1]),
                                rrs_pkg::proj_min(da3[2], da3[3]));
      mxa4 <= rrs_pkg::proj_max(rrs_pkg::proj_max(da3[0], da3[1]),
                                rrs_pkg::proj_max(da3[2], da3[3]));
      mnb4 <= rrs_pkg::proj_min(rrs_pkg::proj_min(db3[0], db3[1]),
                                rrs_pkg::proj_min(db3[2], db3[3]));
      mxb4 <= rrs_pkg::proj_max(rrs_pkg::proj_max(db3[0], db3[1]),
                                rrs_pkg::proj_max(db3[2], db3[3]));
    end
  end

  // Touching intervals do not separate
  assign sep = (mxa4 < mnb4) || (mxb4 < mna4);

  always_ff @(posedge clk) begin
    if (en5) begin
      it5.cand    <= it4.cand;
      it5.overlap <= it4.overlap && !sep;
    end
  end

  `RRS_ASSERT_NEXT(a_cell_load, clk, rst, in_valid && in_ready, v1, "cell dropped a transfer")
  `RRS_ASSERT_NEXT(a_cell_hold, clk, rst, v5 && !out_ready,
                   v5 && $stable(it5.overlap), "cell lost a stalled result")
  `RRS_ASSERT_IMPL(a_cell_empty, clk, rst, !v1, in_ready, "empty cell refused input")

endmodule

FILE: hdl/rotated_rect_sat_overlap.sv
// Separating axis overlap test of a configured reference rectangle against
// a stream of candidate rectangles. One candidate is taken per clock and one
// overlap bit comes out for each, in order, after its transfer passes through the
// eight axis cells of five stages each, then an output register. The depth
// of that cell chain sets the latency; throughput stays one item per cycle
// as long as the output side takes results. The reference corners are read
// by every cell directly, so write them only while no candidate is in flight.
// Depends on rrs_pkg, rrs_cfg and rrs_cell.
`timescale 1ns / 1ps

module rotated_rect_sat_overlap (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cand_x0, cand_y0, cand_x1, cand_y1, cand_x2, cand_y2, cand_x3, cand_y3
  input  logic [rrs_pkg::TDATA_BITS-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // overlap, then zero fill
  output logic [rrs_pkg::ODATA_BITS-1:0]  m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrs_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [rrs_pkg::COORD_BITS-1:0]  cfg_data
);

  rrs_pkg::quad_t ref_quad;
  rrs_pkg::item_t link_item  [rrs_pkg::AXES+1];
  logic           link_valid [rrs_pkg::AXES+1];
  logic           link_ready [rrs_pkg::AXES+1];
  logic           out_overlap;

  rrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ref_quad  (ref_quad)
  );

  // Unpack the candidate; every item starts as overlapping
  always_comb begin
    for (int k = 0; k < rrs_pkg::CORNERS; k++) begin
      link_item[0].cand.x[k] = s_tdata[2*k*rrs_pkg::COORD_BITS +: rrs_pkg::COORD_BITS];
      link_item[0].cand.y[k] =
        s_tdata[(2*k+1)*rrs_pkg::COORD_BITS +: rrs_pkg::COORD_BITS];
    end
    link_item[0].overlap = 1'b1;
  end

  assign link_valid[0] = s_tvalid;
  assign s_tready      = link_ready[0];

  for (genvar g = 0; g < rrs_pkg::AXES; g++) begin : g_cell
    rrs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .axis      (3'(g)),
      .ref_quad  (ref_quad),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_item   (link_item[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_item  (link_item[g+1])
    );
  end

  // Output register: refill when empty or when the held result transfers
  assign link_ready[rrs_pkg::AXES] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (link_ready[rrs_pkg::AXES]) begin
      m_tvalid <= link_valid[rrs_pkg::AXES];
    end
  end

  always_ff @(posedge clk) begin
    if (link_ready[rrs_pkg::AXES]) begin
      out_overlap <= link_item[rrs_pkg::AXES].overlap;
    end
  end

  assign m_tdata = {{(rrs_pkg::ODATA_BITS-1){1'b0}}, out_overlap};

endmodule
